// ----- design/rrsp_pkg.sv -----
`default_nettype none

package rrsp_pkg;

    // Limits of the request format.
    localparam int unsigned MAX_ARGS     = 64;
    localparam int unsigned BUFFER_BYTES = 65536;

    // Field widths.
    localparam int unsigned POS_W    = 17;
    localparam int unsigned NUM_W    = 17;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned OFF_W    = 16;
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned STATUS_W = 3;

    // Largest magnitude kept while reading a number.
    localparam logic [NUM_W-1:0] NUM_CAP = NUM_W'(65536);
    localparam logic [NUM_W-1:0] LEN_MAX = NUM_W'(65535);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] ARGS_LIMIT = CNT_W'(MAX_ARGS);

    // Characters of the protocol.
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Status codes reported with every byte.
    localparam logic [STATUS_W-1:0] ST_INIT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXTRA = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR = 3'd4;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_WAIT,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEAD,
        KIND_LEN,
        KIND_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        NM_LEAD,
        NM_SIGN,
        NM_DIGITS,
        NM_END
    } t_num_mode;

    // Number being read from the current line.
    typedef struct packed {
        t_num_mode        mode;
        logic             negative;
        logic [NUM_W-1:0] value;
    } t_num;

    // One received byte.
    typedef struct packed {
        logic       restart;
        logic [7:0] byte_in;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic [CNT_W-1:0]    args_done;
        logic [CNT_W-1:0]    arg_count;
        logic [LEN_W-1:0]    arg_length;
        logic [OFF_W-1:0]    arg_offset;
        logic [IDX_W-1:0]    arg_index;
        logic [STATUS_W-1:0] status;
        logic                arg_valid;
    } t_result;

    localparam t_num NUM_CLEAR = '{mode: NM_LEAD, negative: 1'b0, value: '0};

    function automatic logic is_white(input logic [7:0] c);
        is_white = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // One step of the atoi-style number reader.
    function automatic t_num feed_number(input t_num n, input t_kind kind,
                                         input logic [7:0] c);
        t_num             r;
        logic             digit;
        logic [3:0]       d;
        logic [NUM_W+3:0] v;
        r     = n;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d     = digit ? 4'(c - CH_ZERO) : 4'd0;
        v     = ({3'b000, n.value, 1'b0} + {1'b0, n.value, 3'b000})
                + {(NUM_W)'(0), d};
        if (kind != KIND_OTHER) begin
            case (n.mode)
                NM_LEAD: begin
                    if (is_white(c)) begin
                        r.mode = NM_LEAD;
                    end else if (c == CH_PLUS) begin
                        r.mode = NM_SIGN;
                    end else if (c == CH_MINUS) begin
                        r.mode     = NM_SIGN;
                        r.negative = 1'b1;
                    end else if (digit) begin
                        r.mode  = NM_DIGITS;
                        r.value = NUM_W'(d);
                    end else begin
                        r.mode = NM_END;
                    end
                end
                NM_SIGN: begin
                    if (digit) begin
                        r.mode  = NM_DIGITS;
                        r.value = NUM_W'(d);
                    end else begin
                        r.mode = NM_END;
                    end
                end
                NM_DIGITS: begin
                    if (digit) begin
                        r.value = (v > {4'b0000, NUM_CAP}) ? NUM_CAP : v[NUM_W-1:0];
                    end else begin
                        r.mode = NM_END;
                    end
                end
                default: begin
                    r = n;
                end
            endcase
        end
        feed_number = r;
    endfunction

endpackage

`default_nettype wire

// ----- design/rrsp_in_stage.sv -----
`default_nettype none

module rrsp_in_stage
    import rrsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The register takes a new byte when empty or when its byte moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- design/rrsp_engine.sv -----
`default_nettype none

module rrsp_engine
    import rrsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_result    o_result
);

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_at_start, n_at_start;
    t_kind            r_kind, n_kind;
    logic             r_pending_cr, n_pending_cr;
    t_num             r_num, n_num;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_fin, n_fin;
    logic             r_expect, n_expect;
    logic             r_extra, n_extra;

    // Parse state advances once per byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_INIT;
            r_pos        <= '0;
            r_at_start   <= 1'b1;
            r_kind       <= KIND_HEAD;
            r_pending_cr <= 1'b0;
            r_num        <= NUM_CLEAR;
            r_total      <= '0;
            r_fin        <= '0;
            r_expect     <= 1'b0;
            r_extra      <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_at_start   <= n_at_start;
            r_kind       <= n_kind;
            r_pending_cr <= n_pending_cr;
            r_num        <= n_num;
            r_total      <= n_total;
            r_fin        <= n_fin;
            r_expect     <= n_expect;
            r_extra      <= n_extra;
        end
    end

    // Next state and the result of the current byte.
    always_comb begin
        logic       line_end;
        logic       neg;
        logic [7:0] b;
        t_num       num;
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_at_start   = r_at_start;
        n_kind       = r_kind;
        n_pending_cr = r_pending_cr;
        n_total      = r_total;
        n_fin        = r_fin;
        n_expect     = r_expect;
        n_extra      = r_extra;
        o_result     = '0;
        b            = i_item.byte_in;
        num          = r_num;
        line_end     = 1'b0;
        neg          = r_num.negative && (r_num.value != '0);

        if (i_item.restart) begin
            n_phase      = PH_INIT;
            n_pos        = '0;
            n_at_start   = 1'b1;
            n_kind       = KIND_HEAD;
            n_pending_cr = 1'b0;
            num          = NUM_CLEAR;
            n_total      = '0;
            n_fin        = '0;
            n_expect     = 1'b0;
            n_extra      = 1'b0;
        end else begin
            unique case (r_phase)
                PH_DONE: begin
                    n_extra = 1'b1;
                end
                PH_ERR: begin
                    n_phase = PH_ERR;
                end
                default: begin
                    if (r_pos >= POS_LIMIT) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                        // A CR not followed by LF counts as an ordinary byte.
                        if (r_pending_cr) begin
                            n_pending_cr = 1'b0;
                            if (b == CH_LF) begin
                                line_end = 1'b1;
                            end else begin
                                num = feed_number(num, r_kind, CH_CR);
                            end
                        end
                        if (!line_end) begin
                            if (r_at_start) begin
                                n_at_start = 1'b0;
                                num        = NUM_CLEAR;
                                if (r_phase == PH_INIT) begin
                                    n_kind = KIND_HEAD;
                                    if (b != CH_STAR) begin
                                        n_phase = PH_ERR;
                                    end
                                end else if (!r_expect && b == CH_DOLL) begin
                                    n_kind = KIND_LEN;
                                end else begin
                                    n_kind = KIND_OTHER;
                                end
                                if (b == CH_CR) begin
                                    n_pending_cr = 1'b1;
                                end
                            end else if (b == CH_CR) begin
                                n_pending_cr = 1'b1;
                            end else begin
                                num = feed_number(num, r_kind, b);
                            end
                        end else begin
                            n_at_start = 1'b1;
                            unique case (r_kind)
                                KIND_HEAD: begin
                                    if (neg || r_num.value > NUM_W'(ARGS_LIMIT)) begin
                                        n_phase = PH_ERR;
                                    end else begin
                                        n_total = CNT_W'(r_num.value);
                                        n_phase = (r_num.value == '0) ? PH_DONE : PH_WAIT;
                                    end
                                end
                                KIND_LEN: begin
                                    o_result.arg_valid  = 1'b1;
                                    o_result.arg_index  = IDX_W'(r_fin);
                                    o_result.arg_offset = n_pos[OFF_W-1:0];
                                    if (neg) begin
                                        o_result.arg_length = '1;
                                    end else if (r_num.value > LEN_MAX) begin
                                        o_result.arg_length = LEN_W'(LEN_MAX);
                                    end else begin
                                        o_result.arg_length = LEN_W'(r_num.value);
                                    end
                                    n_expect = 1'b1;
                                end
                                default: begin
                                    n_expect = 1'b0;
                                    n_fin    = r_fin + CNT_W'(1);
                                    if (n_fin >= r_total) begin
                                        n_phase = PH_DONE;
                                    end
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
        n_num = num;

        // Status follows the phase after this byte.
        unique case (n_phase)
            PH_INIT: o_result.status = ST_INIT;
            PH_WAIT: o_result.status = ST_WAIT;
            PH_DONE: o_result.status = n_extra ? ST_EXTRA : ST_DONE;
            default: o_result.status = ST_ERROR;
        endcase
        o_result.arg_count = n_total;
        o_result.args_done = n_fin;
    end

endmodule

`default_nettype wire

// ----- design/rrsp_out_stage.sv -----
`default_nettype none

module rrsp_out_stage
    import rrsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // The register can load when empty or when the downstream takes it now.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- design/resp_request_stream_parser.sv -----
`default_nettype none
// Channel   Direction  Ports           Content
// s_axis    in         tdata[7:0]      byte_in
//                      tuser[0]        restart
// m_axis    out        tdata[55:0]     status, arg_index, arg_offset, arg_length,
//                                      arg_count, args_done
//                      tuser[0]        arg_valid
//
// One byte is taken per cycle while the output is not stalled; its result is computed
// from the input register by the engine and presented from the output register.
// The rate is set by the parse state update in the engine, one byte per clock when not stalled.
// Reset is synchronous and active low and clears the parse state and both stages.
// A stalled output holds its transaction; the input register then takes one more
// byte only if it is empty, and the input stalls until the output transaction is taken.

module resp_request_stream_parser
    import rrsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  wire logic        i_s_axis_tuser,   // [0] restart
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [55:0]      o_m_axis_tdata,   // [2:0] status, [8:3] arg_index,
                                               // [24:9] arg_offset, [41:25] arg_length,
                                               // [48:42] arg_count, [55:49] args_done
    output logic             o_m_axis_tuser    // [0] arg_valid
);

    t_item   s_in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    out_free;
    logic    fire;
    t_result eng_result;
    t_result out_result;

    assign s_in_item.byte_in = i_s_axis_tdata;
    assign s_in_item.restart = i_s_axis_tuser;

    // A byte in the input register is processed when the output register can load.
    assign fire = stage_valid && out_free;

    rrsp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (s_in_item),
        .i_advance (fire),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    rrsp_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (eng_result)
    );

    rrsp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (eng_result),
        .i_ready  (i_m_axis_tready),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_result)
    );

    // Pack the result fields from the lowest bit up.
    assign o_m_axis_tdata = {out_result.args_done, out_result.arg_count,
                             out_result.arg_length, out_result.arg_offset,
                             out_result.arg_index, out_result.status};
    assign o_m_axis_tuser = out_result.arg_valid;

    // An argument entry is only reported while arguments are still pending.
    a_entry_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[2:0] == ST_WAIT))
        else $error("argument entry reported outside the waiting status");

    // An entry index always refers to an argument the header declared.
    a_entry_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        ({1'b0, o_m_axis_tdata[8:3]} < o_m_axis_tdata[48:42]))
        else $error("argument index beyond the declared count");

    // Completed data lines never exceed the declared count.
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[55:49] <= o_m_axis_tdata[48:42]))
        else $error("completed arguments exceed the declared count");

endmodule

`default_nettype wire
